@@ design/cms_pkg.sv @@
// ----------------------------------------------------------------------------
// cms_pkg
// Types and constants shared by the CAN message segmenter modules.
// ----------------------------------------------------------------------------
package cms_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned ID_W     = 16;
   localparam int unsigned LEN_W    = 4;
   localparam int unsigned DATA_W   = 64;
   localparam int unsigned BUF_W    = 56;
   localparam int unsigned FILL_W   = 3;
   localparam int unsigned RSP_DATA_W = 88;

   // One CAN frame as produced by the framer.
   typedef struct packed {
      logic                  end_of_message;
      logic [DATA_W-1:0]     frame_data;
      logic [LEN_W-1:0]      frame_len;
      logic [ID_W-1:0]       frame_id;
   } cms_frame_type;

endpackage

@@ design/cms_framer.sv @@
// ----------------------------------------------------------------------------
// cms_framer
// Tracks the byte phase of the current message, gathers payload bytes and
// raises a frame when it is full or when the message ends.
// ----------------------------------------------------------------------------
module cms_framer import cms_pkg::*; #(
   parameter int unsigned PAYLOAD_PER_FRAME = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [BYTE_W-1:0]    msg_byte,
   input  logic                 first,
   input  logic                 last,
   output logic                 emit,
   output cms_frame_type        frame
);

   localparam logic [1:0] PHASE_ADDR = 2'd0;
   localparam logic [1:0] PHASE_FUNC = 2'd1;
   localparam logic [1:0] PHASE_DATA = 2'd2;
   localparam int unsigned PBUF_W    = PAYLOAD_PER_FRAME * BYTE_W;
   localparam logic [FILL_W-1:0] FULL_COUNT = FILL_W'(PAYLOAD_PER_FRAME);

   logic [1:0]          phase_ff,   phase_in;
   logic [BYTE_W-1:0]   addr_ff,    addr_in;
   logic [BYTE_W-1:0]   func_ff,    func_in;
   logic [BYTE_W-1:0]   pkt_ff,     pkt_in;
   logic [FILL_W-1:0]   fill_ff,    fill_in;
   logic [PBUF_W-1:0]   buf_ff,     buf_in;
   logic [PBUF_W-1:0]   merged;
   logic [FILL_W-1:0]   count;

   // The incoming byte drops into the lane picked by the fill count.
   always_comb begin
      merged = buf_ff;
      for (int i = 0; i < PAYLOAD_PER_FRAME; i++) begin
         if (fill_ff == FILL_W'(i)) begin
            merged[i*BYTE_W +: BYTE_W] = msg_byte;
         end
      end
   end

   assign count = fill_ff + FILL_W'(1);

   always_comb begin
      phase_in = phase_ff;
      addr_in  = addr_ff;
      func_in  = func_ff;
      pkt_in   = pkt_ff;
      fill_in  = fill_ff;
      buf_in   = buf_ff;
      emit     = 1'b0;
      frame.frame_id       = {addr_ff, pkt_ff};
      frame.frame_len      = {1'b0, count} + LEN_W'(1);
      frame.frame_data     = {BUF_W'(merged), func_ff};
      frame.end_of_message = last;
      if (accept) begin
         if (first) begin
            // A start mark always opens a new message; a partial frame is lost.
            addr_in  = msg_byte;
            pkt_in   = '0;
            fill_in  = '0;
            buf_in   = '0;
            phase_in = last ? PHASE_ADDR : PHASE_FUNC;
         end else begin
            case (phase_ff)
               PHASE_FUNC: begin
                  func_in  = msg_byte;
                  phase_in = last ? PHASE_ADDR : PHASE_DATA;
               end
               PHASE_DATA: begin
                  if (last || count == FULL_COUNT) begin
                     emit    = 1'b1;
                     pkt_in  = pkt_ff + BYTE_W'(1);
                     fill_in = '0;
                     buf_in  = '0;
                     if (last) begin
                        phase_in = PHASE_ADDR;
                     end
                  end else begin
                     buf_in  = merged;
                     fill_in = count;
                  end
               end
               default: begin
                  // Bytes without a start mark are ignored here.
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_ADDR;
         addr_ff  <= '0;
         func_ff  <= '0;
         pkt_ff   <= '0;
         fill_ff  <= '0;
         buf_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         addr_ff  <= addr_in;
         func_ff  <= func_in;
         pkt_ff   <= pkt_in;
         fill_ff  <= fill_in;
         buf_ff   <= buf_in;
      end
   end

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff < FULL_COUNT)
      else $error("payload fill count reached a full frame without emitting");

   a_end_returns_to_addr: assert property (@(posedge clock) disable iff (reset)
      emit && last |=> phase_ff == PHASE_ADDR)
      else $error("final frame did not return to the address phase");

endmodule

@@ design/can_message_segmenter.sv @@
// ----------------------------------------------------------------------------
// can_message_segmenter
// Cuts a byte stream of command messages into CAN frames.
// ----------------------------------------------------------------------------
// Message bytes enter one per beat; req_tuser marks the address byte that
// starts a message and req_tlast the final byte. Every byte is handled in the
// cycle it is accepted, so a new byte can be taken every cycle while the
// second output entry is empty. A finished frame goes to a two-entry output
// register; input ready depends only on whether the second entry is occupied,
// so a waiting frame does not stall the input until a second one is waiting.
// ----------------------------------------------------------------------------
module can_message_segmenter import cms_pkg::*; #(
   parameter int unsigned PAYLOAD_PER_FRAME = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BYTE_W-1:0]     req_tdata,   // [7:0] msg_byte
   input  logic                  req_tuser,   // [0] first
   input  logic                  req_tlast,   // last
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [15:0] frame_id, [19:16] frame_len,
                                              // [83:20] frame_data, [87:84] zero
   output logic                  rsp_tlast    // end_of_message
);

   logic          accept;
   logic          emit;
   cms_frame_type new_frame;
   logic          main_free;

   logic          main_valid_ff, main_valid_in;
   cms_frame_type main_ff,       main_in;
   logic          skid_valid_ff, skid_valid_in;
   cms_frame_type skid_ff,       skid_in;

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;

   cms_framer #(
      .PAYLOAD_PER_FRAME (PAYLOAD_PER_FRAME)
   ) u_framer (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .msg_byte (req_tdata),
      .first    (req_tuser),
      .last     (req_tlast),
      .emit     (emit),
      .frame    (new_frame)
   );

   assign main_free = !main_valid_ff || rsp_tready;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_in       = main_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (main_free) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = skid_ff;
            skid_valid_in = emit;
            skid_in       = new_frame;
         end else begin
            main_valid_in = emit;
            main_in       = new_frame;
         end
      end else if (emit) begin
         skid_valid_in = 1'b1;
         skid_in       = new_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = main_valid_ff;
   assign rsp_tdata  = {4'b0000, main_ff.frame_data, main_ff.frame_len, main_ff.frame_id};
   assign rsp_tlast  = main_ff.end_of_message;

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("second output entry holds a frame while the first is empty");

   a_skid_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(main_valid_ff && !rsp_tready))
      else $error("second output entry filled although the first was free");

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> main_ff.frame_len >= LEN_W'(2)
                     && main_ff.frame_len <= LEN_W'(PAYLOAD_PER_FRAME + 1))
      else $error("frame length outside the legal range");

endmodule
